/* hw/rtl/chs_pkg.sv */
// shared types, codes and constants for the chained hash set
package chs_pkg;

    // default geometry (powers of two)
    localparam int ROWS_DEF    = 4096;
    localparam int BUCKETS_DEF = 8192;

    // fixed field widths
    localparam int HASH_W      = 64;
    localparam int KEY_W       = 64;
    localparam int KEY_LIMIT_W = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int STATUS_W    = 3;

    localparam logic [KEY_LIMIT_W-1:0] KEY_LIMIT_RST = 13'd4096;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MULTISET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_ONLY = 2'd2;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NEXT   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE    = 3'd0,
        ST_MATCH   = 3'd1,
        ST_NEW     = 3'd2,
        ST_DUP     = 3'd3,
        ST_FULL    = 3'd4,
        ST_OVER    = 3'd5
    } status_t;

    // key record as stored per row and as probed
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [KEY_W-1:0]  key;
        logic              is_null;
    } key_rec_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_DECIDE,
        S_DUP_GROUP,
        S_DUP_LINK,
        S_NEXT,
        S_OUT
    } state_t;

endpackage

/* hw/rtl/chained_hash_set_insert_find.sv */
// A skipped item goes straight to S_OUT; CMD_NEXT passes S_NEXT; find or insert
// passes S_HEAD, one S_WALK per chain row visited and S_DECIDE; a multiset
// duplicate adds S_DUP_GROUP and S_DUP_LINK. Clear writes one bucket entry per
// cycle on the write port. One item is in work at a time; a new item is accepted
// while the last result waits. After reset a clearing pass empties the bucket
// memory before in_ready rises; configuration writes are taken at all times.
module chained_hash_set_insert_find #(
    parameter int ROWS    = chs_pkg::ROWS_DEF,
    parameter int BUCKETS = chs_pkg::BUCKETS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [chs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chs_pkg::KEY_LIMIT_W-1:0]    cfg_data,
    // input items
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         command,
    input  logic [chs_pkg::HASH_W-1:0]         hash_value,
    input  logic [chs_pkg::KEY_W-1:0]          key_value,
    input  logic                               key_null,
    input  logic                               selected,
    input  logic [$clog2(ROWS)-1:0]            row_index,
    // result items
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [$clog2(ROWS)-1:0]            row_id,
    output logic [chs_pkg::STATUS_W-1:0]       status,
    output logic [$clog2(ROWS):0]              stored_rows
);
    import chs_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int PW    = RW + 1;
    localparam int BW    = $clog2(BUCKETS);
    localparam int REC_W = $bits(key_rec_t);
    localparam int ROW_W = PW + REC_W;
    localparam int CW    = (PW > KEY_LIMIT_W) ? PW : KEY_LIMIT_W;
    localparam logic [PW-1:0] NONE = PW'(ROWS);
    localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

    // control state
    state_t             state_reg, state_next;
    logic [PW-1:0]      rc_reg, rc_next;
    logic [PW-1:0]      gc_reg, gc_next;
    logic [BW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               clr_item_reg, clr_item_next;
    logic               out_valid_reg, out_valid_next;
    logic               multiset_reg;
    logic [KEY_LIMIT_W-1:0] key_limit_reg;
    logic               hash_only_reg;

    // item payload and work registers
    cmd_t               cmd_reg, cmd_next;
    key_rec_t           probe_reg, probe_next;
    logic [RW-1:0]      idx_reg, idx_next;
    logic [BW-1:0]      bkt_reg, bkt_next;
    logic [PW-1:0]      head_reg, head_next;
    logic [PW-1:0]      cur_reg, cur_next;
    logic               found_reg, found_next;
    logic [RW-1:0]      g_reg, g_next;
    logic [RW-1:0]      res_rid_reg, res_rid_next;
    status_t            res_st_reg, res_st_next;
    logic [RW-1:0]      out_rid_reg, out_rid_next;
    status_t            out_st_reg, out_st_next;
    logic [PW-1:0]      out_rows_reg, out_rows_next;

    // memory ports
    logic               bkt_we;
    logic [BW-1:0]      bkt_waddr, bkt_raddr;
    logic [PW-1:0]      bkt_wdata, bkt_rdata;
    logic               row_we;
    logic [RW-1:0]      row_waddr, row_raddr;
    logic [ROW_W-1:0]   row_wdata, row_rdata;
    logic               gn_we;
    logic [RW-1:0]      gn_waddr, gn_raddr;
    logic [PW-1:0]      gn_wdata, gn_rdata;
    logic               gor_we;
    logic [RW-1:0]      gor_waddr, gor_raddr;
    logic [RW-1:0]      gor_wdata, gor_rdata;
    logic               gl_we;
    logic [RW-1:0]      gl_waddr, gl_raddr;
    logic [RW-1:0]      gl_wdata, gl_rdata;

    key_rec_t           row_rec;
    logic [PW-1:0]      row_prev;
    logic               row_hit;
    logic [PW-1:0]      rc_inc;
    logic [PW-1:0]      rc_dec;

    assign row_rec  = key_rec_t'(row_rdata[REC_W-1:0]);
    assign row_prev = row_rdata[ROW_W-1 -: PW];
    assign rc_inc   = rc_reg + PW'(1);
    assign rc_dec   = rc_reg - PW'(1);

    // bucket heads, row records with chain links, group links
    chs_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_bucket_ram (
        .clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
        .raddr(bkt_raddr), .rdata(bkt_rdata)
    );
    chs_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_row_ram (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );
    chs_ram #(.WIDTH(PW), .DEPTH(ROWS)) u_gnext_ram (
        .clk(clk), .we(gn_we), .waddr(gn_waddr), .wdata(gn_wdata),
        .raddr(gn_raddr), .rdata(gn_rdata)
    );
    chs_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_gofrow_ram (
        .clk(clk), .we(gor_we), .waddr(gor_waddr), .wdata(gor_wdata),
        .raddr(gor_raddr), .rdata(gor_rdata)
    );
    chs_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_glast_ram (
        .clk(clk), .we(gl_we), .waddr(gl_waddr), .wdata(gl_wdata),
        .raddr(gl_raddr), .rdata(gl_rdata)
    );

    chs_match u_match (
        .probe(probe_reg), .stored(row_rec), .hash_only(hash_only_reg), .hit(row_hit)
    );

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign row_id      = out_rid_reg;
    assign status      = out_st_reg;
    assign stored_rows = out_rows_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiset_reg  <= 1'b0;
            key_limit_reg <= KEY_LIMIT_RST;
            hash_only_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MULTISET:  multiset_reg  <= cfg_data[0];
                CFG_KEY_LIMIT: key_limit_reg <= cfg_data;
                CFG_HASH_ONLY: hash_only_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rc_reg        <= '0;
            gc_reg        <= '0;
            clr_cnt_reg   <= '0;
            clr_item_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rc_reg        <= rc_next;
            gc_reg        <= gc_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_item_reg  <= clr_item_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        probe_reg    <= probe_next;
        idx_reg      <= idx_next;
        bkt_reg      <= bkt_next;
        head_reg     <= head_next;
        cur_reg      <= cur_next;
        found_reg    <= found_next;
        g_reg        <= g_next;
        res_rid_reg  <= res_rid_next;
        res_st_reg   <= res_st_next;
        out_rid_reg  <= out_rid_next;
        out_st_reg   <= out_st_next;
        out_rows_reg <= out_rows_next;
    end

    // sequencer: next state, memory accesses, result
    always_comb
    begin
        state_next     = state_reg;
        rc_next        = rc_reg;
        gc_next        = gc_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_item_next  = clr_item_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd_next       = cmd_reg;
        probe_next     = probe_reg;
        idx_next       = idx_reg;
        bkt_next       = bkt_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        found_next     = found_reg;
        g_next         = g_reg;
        res_rid_next   = res_rid_reg;
        res_st_next    = res_st_reg;
        out_rid_next   = out_rid_reg;
        out_st_next    = out_st_reg;
        out_rows_next  = out_rows_reg;

        bkt_we    = 1'b0;
        bkt_waddr = bkt_reg;
        bkt_wdata = rc_reg;
        bkt_raddr = hash_value[BW-1:0];
        row_we    = 1'b0;
        row_waddr = rc_reg[RW-1:0];
        row_wdata = {head_reg, probe_reg};
        row_raddr = cur_reg[RW-1:0];
        gn_we     = 1'b0;
        gn_waddr  = rc_reg[RW-1:0];
        gn_wdata  = NONE;
        gn_raddr  = row_index;
        gor_we    = 1'b0;
        gor_waddr = rc_reg[RW-1:0];
        gor_wdata = gc_reg[RW-1:0];
        gor_raddr = cur_reg[RW-1:0];
        gl_we     = 1'b0;
        gl_waddr  = gc_reg[RW-1:0];
        gl_wdata  = rc_reg[RW-1:0];
        gl_raddr  = gor_rdata;

        case (state_reg)
            // clearing pass over the bucket memory
            S_CLEAR:
            begin
                bkt_we       = 1'b1;
                bkt_waddr    = clr_cnt_reg;
                bkt_wdata    = NONE;
                clr_cnt_next = clr_cnt_reg + BW'(1);
                if (clr_cnt_reg == LAST_BKT)
                begin
                    clr_cnt_next  = '0;
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? S_OUT : S_IDLE;
                end
            end

            // take an item, start bucket and group-link reads
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next         = cmd_t'(command);
                    probe_next.hash  = hash_value;
                    probe_next.key   = key_value;
                    probe_next.is_null = key_null;
                    idx_next         = row_index;
                    bkt_next         = hash_value[BW-1:0];
                    res_rid_next     = '0;
                    res_st_next      = ST_NONE;
                    if (!selected)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        case (cmd_t'(command))
                            CMD_FIND, CMD_INSERT: state_next = S_HEAD;
                            CMD_CLEAR:
                            begin
                                rc_next       = '0;
                                gc_next       = '0;
                                clr_cnt_next  = '0;
                                clr_item_next = 1'b1;
                                state_next    = S_CLEAR;
                            end
                            CMD_NEXT:             state_next = S_NEXT;
                            default:              state_next = S_OUT;
                        endcase
                    end
                end
            end

            // bucket head arrives
            S_HEAD:
            begin
                head_next = bkt_rdata;
                cur_next  = bkt_rdata;
                row_raddr = bkt_rdata[RW-1:0];
                if (bkt_rdata < rc_reg)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            // one chain row per cycle
            S_WALK:
            begin
                row_raddr = row_prev[RW-1:0];
                if (row_hit)
                begin
                    found_next = 1'b1;
                    state_next = S_DECIDE;
                end
                else
                begin
                    cur_next = row_prev;
                    if (row_prev >= rc_reg)
                    begin
                        found_next = 1'b0;
                        state_next = S_DECIDE;
                    end
                end
            end

            // find result or insert decision
            S_DECIDE:
            begin
                state_next = S_OUT;
                if (cmd_reg == CMD_FIND)
                begin
                    if (found_reg)
                    begin
                        res_rid_next = cur_reg[RW-1:0];
                        res_st_next  = ST_MATCH;
                    end
                end
                else if (!multiset_reg && found_reg)
                begin
                    res_rid_next = cur_reg[RW-1:0];
                    res_st_next  = ST_MATCH;
                end
                else if (!multiset_reg && (CW'(rc_reg) > CW'(key_limit_reg)))
                begin
                    res_rid_next = rc_dec[RW-1:0];
                    res_st_next  = ST_OVER;
                end
                else if (rc_reg == NONE)
                begin
                    res_st_next = ST_FULL;
                end
                else if (!found_reg)
                begin
                    // new row heads its bucket chain and its own group
                    row_we       = 1'b1;
                    bkt_we       = 1'b1;
                    gn_we        = 1'b1;
                    gor_we       = 1'b1;
                    gl_we        = 1'b1;
                    rc_next      = rc_inc;
                    gc_next      = gc_reg + PW'(1);
                    res_rid_next = rc_reg[RW-1:0];
                    res_st_next  = ST_NEW;
                end
                else
                begin
                    // duplicate: store row, look up group of the match
                    row_we     = 1'b1;
                    gn_we      = 1'b1;
                    state_next = S_DUP_GROUP;
                end
            end

            // group id arrives, fetch its last row
            S_DUP_GROUP:
            begin
                g_next     = gor_rdata;
                gl_raddr   = gor_rdata;
                gor_we     = 1'b1;
                gor_wdata  = gor_rdata;
                state_next = S_DUP_LINK;
            end

            // link new row after the group's last row
            S_DUP_LINK:
            begin
                gn_we        = 1'b1;
                gn_waddr     = gl_rdata;
                gn_wdata     = rc_reg;
                gl_we        = 1'b1;
                gl_waddr     = g_reg;
                rc_next      = rc_inc;
                res_rid_next = cur_reg[RW-1:0];
                res_st_next  = ST_DUP;
                state_next   = S_OUT;
            end

            // group successor arrives
            S_NEXT:
            begin
                if ((PW'(idx_reg) < rc_reg) && (gn_rdata < rc_reg))
                begin
                    res_rid_next = gn_rdata[RW-1:0];
                    res_st_next  = ST_MATCH;
                end
                state_next = S_OUT;
            end

            // hand the result to the output register
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_rid_next   = res_rid_reg;
                    out_st_next    = res_st_reg;
                    out_rows_next  = rc_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/chs_ram.sv */
// generic single-write, single-read synchronous ram with registered read
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/chs_match.sv */
// row compare: hash equality, then key or null equality unless hash_only is set
module chs_match (
    input  chs_pkg::key_rec_t probe,
    input  chs_pkg::key_rec_t stored,
    input  logic              hash_only,
    output logic              hit
);
    import chs_pkg::*;

    logic hash_eq;
    logic key_eq;

    assign hash_eq = (probe.hash == stored.hash);

    // nulls equal only nulls, key bits ignored then
    always_comb
    begin
        if (probe.is_null || stored.is_null)
        begin
            key_eq = (probe.is_null == stored.is_null);
        end
        else
        begin
            key_eq = (probe.key == stored.key);
        end
    end

    assign hit = hash_eq && (hash_only || key_eq);

endmodule

/* hw/rtl/chs_checker.sv */
// port-level checks for the chained hash set, bound to the top level
module chs_checker #(
    parameter int ROWS = chs_pkg::ROWS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [$clog2(ROWS)-1:0]       row_id,
    input logic [chs_pkg::STATUS_W-1:0]  status,
    input logic [$clog2(ROWS):0]         stored_rows
);
    import chs_pkg::*;

    localparam int PW = $clog2(ROWS) + 1;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_id) && $stable(status)
            && $stable(stored_rows))
        else $error("stalled result changed");

    // no undefined status codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_OVER))
        else $error("undefined status code");

    // no-result and full answers carry row zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NONE || status == ST_FULL) |-> row_id == '0)
        else $error("row id not zero on empty result");

    // a new key is the newest stored row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NEW) |-> (PW'(row_id) + PW'(1)) == stored_rows)
        else $error("new row id does not match row count");

endmodule

bind chained_hash_set_insert_find chs_checker #(.ROWS(ROWS)) u_chs_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .row_id(row_id),
    .status(status),
    .stored_rows(stored_rows)
);

/* verif/tb_chained_hash_set_insert_find.sv */
// self-checking testbench for the chained hash set / multiset block
`timescale 1ns / 1ps

module tb_chained_hash_set_insert_find;
    import chs_pkg::*;

    localparam int ROWS    = ROWS_DEF;
    localparam int BUCKETS = BUCKETS_DEF;
    localparam int RW      = $clog2(ROWS);
    localparam int NONE    = ROWS;

    typedef enum logic [1:0] { K_ITEM, K_CFG, K_DRAIN } kind_t;

    typedef struct {
        kind_t                  kind;
        cmd_t                   cmd;
        logic [HASH_W-1:0]      hash;
        logic [KEY_W-1:0]       key;
        logic                   nul;
        logic                   sel;
        logic [RW-1:0]          idx;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [KEY_LIMIT_W-1:0] reg_data;
    } item_t;

    typedef struct {
        logic [RW-1:0] row;
        status_t       st;
        logic [RW:0]   rows;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_LIMIT_W-1:0] cfg_data;
    logic in_valid, in_ready;
    logic [1:0] command;
    logic [HASH_W-1:0] hash_value;
    logic [KEY_W-1:0] key_value;
    logic key_null, selected;
    logic [RW-1:0] row_index;
    logic out_valid, out_ready;
    logic [RW-1:0] row_id;
    logic [STATUS_W-1:0] status;
    logic [RW:0] stored_rows;

    chained_hash_set_insert_find dut (.*);

    always #2 clk = ~clk;

    // shadow copy of the table
    int unsigned        m_multi, m_limit, m_hash_only;
    int unsigned        m_head [BUCKETS];
    int unsigned        m_prev [ROWS];
    logic [HASH_W-1:0]  m_hash [ROWS];
    logic [KEY_W-1:0]   m_key  [ROWS];
    logic               m_null [ROWS];
    int unsigned        m_gnext [ROWS];
    int unsigned        m_group [ROWS];
    int unsigned        m_glast [ROWS];
    int unsigned        m_rows, m_groups;

    item_t   item_q[$];
    result_t result_q[$];
    int      errors = 0;
    int      results_seen = 0;

    function automatic void empty_model();
        for (int i = 0; i < BUCKETS; i++) m_head[i] = NONE;
        m_rows = 0;
        m_groups = 0;
    endfunction

    function automatic item_t blank_item();
        item_t it;
        it.kind = K_ITEM; it.cmd = CMD_FIND; it.hash = '0; it.key = '0;
        it.nul = 1'b0; it.sel = 1'b0; it.idx = '0;
        it.reg_idx = '0; it.reg_data = '0;
        return it;
    endfunction

    function automatic bit row_equal(int unsigned r, item_t it);
        if (m_hash[r] != it.hash) return 0;
        if (m_hash_only != 0) return 1;
        if (it.nul || m_null[r]) return it.nul == m_null[r];
        return m_key[r] == it.key;
    endfunction

    function automatic int unsigned chain_find(int unsigned b, item_t it);
        int unsigned r;
        int unsigned steps;
        r = m_head[b];
        steps = 0;
        while (r < m_rows && steps <= ROWS) begin
            if (row_equal(r, it)) return r;
            r = m_prev[r];
            steps++;
        end
        return NONE;
    endfunction

    function automatic int unsigned add_row(item_t it);
        int unsigned r;
        r = m_rows;
        m_hash[r] = it.hash;
        m_key[r] = it.key;
        m_null[r] = it.nul;
        m_gnext[r] = NONE;
        m_rows++;
        return r;
    endfunction

    function automatic void link_head(int unsigned r, int unsigned b);
        m_prev[r] = m_head[b];
        m_head[b] = r;
        m_group[r] = m_groups;
        m_glast[m_groups] = r;
        m_groups++;
    endfunction

    // compute the result of one item and update the shadow table
    function automatic result_t table_step(item_t it);
        result_t     res;
        int unsigned b, m, r, g, last;
        res.row = '0;
        res.st = ST_NONE;
        b = 32'(it.hash % BUCKETS);
        if (it.sel) begin
            case (it.cmd)
                CMD_FIND: begin
                    m = chain_find(b, it);
                    if (m != NONE) begin res.row = RW'(m); res.st = ST_MATCH; end
                end
                CMD_INSERT: begin
                    m = chain_find(b, it);
                    if (m_multi == 0) begin
                        if (m != NONE) begin
                            res.row = RW'(m); res.st = ST_MATCH;
                        end else if (m_rows > m_limit) begin
                            res.row = RW'(m_rows - 1); res.st = ST_OVER;
                        end else if (m_rows >= ROWS) begin
                            res.st = ST_FULL;
                        end else begin
                            r = add_row(it);
                            link_head(r, b);
                            res.row = RW'(r); res.st = ST_NEW;
                        end
                    end else if (m_rows >= ROWS) begin
                        res.st = ST_FULL;
                    end else begin
                        r = add_row(it);
                        if (m == NONE) begin
                            link_head(r, b);
                            res.row = RW'(r); res.st = ST_NEW;
                        end else begin
                            g = m_group[m] % ROWS;
                            last = m_glast[g] % ROWS;
                            m_gnext[last] = r;
                            m_glast[g] = r;
                            m_group[r] = g;
                            res.row = RW'(m); res.st = ST_DUP;
                        end
                    end
                end
                CMD_CLEAR: empty_model();
                default: begin
                    if (it.idx < m_rows) begin
                        m = m_gnext[it.idx];
                        if (m < m_rows) begin res.row = RW'(m); res.st = ST_MATCH; end
                    end
                end
            endcase
        end
        res.rows = (RW+1)'(m_rows);
        return res;
    endfunction

    // stimulus helpers
    task automatic add_item(cmd_t c, logic [63:0] h, logic [63:0] k, logic n,
                            logic s, logic [RW-1:0] i);
        item_t it;
        it = blank_item();
        it.kind = K_ITEM; it.cmd = c; it.hash = h; it.key = k;
        it.nul = n; it.sel = s; it.idx = i;
        item_q.insert(item_q.size(), it);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] ri, int unsigned d);
        item_t it;
        it = blank_item();
        it.kind = K_CFG; it.reg_idx = ri; it.reg_data = KEY_LIMIT_W'(d);
        item_q.insert(item_q.size(), it);
    endtask

    task automatic add_drain();
        item_t it;
        it = blank_item();
        it.kind = K_DRAIN;
        item_q.insert(item_q.size(), it);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // accepted items are stepped through the shadow copy, and config writes are applied to it as they are taken
    bit in_taken, cfg_taken, out_taken;

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            item_t it;
            it = blank_item();
            it.cmd = cmd_t'(command); it.hash = hash_value; it.key = key_value;
            it.nul = key_null; it.sel = selected; it.idx = row_index;
            result_q.insert(result_q.size(), table_step(it));
            in_taken = 1;
        end
        if (rst_n && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MULTISET:  m_multi = cfg_data[0];
                CFG_KEY_LIMIT: m_limit = 32'(cfg_data);
                CFG_HASH_ONLY: m_hash_only = cfg_data[0];
                default: ;
            endcase
            cfg_taken = 1;
        end
    end

    // driver: one pending item at a time, random gaps between items
    int   gap_cnt = 0;
    int   settle = 0;
    bit   burst = 0;
    logic nv_in, nv_cfg;

    always @(negedge clk) begin
        if (rst_n) begin
            nv_in = in_valid && !in_taken;
            nv_cfg = cfg_valid && !cfg_taken;
            in_taken = 0;
            cfg_taken = 0;
            if (!nv_in && !nv_cfg && result_q.size() == 0) settle++;
            else settle = 0;
            if (!nv_in && !nv_cfg) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (item_q.size() != 0) begin
                    if (item_q[0].kind == K_ITEM) begin
                        item_t it;
                        it = item_q.pop_front();
                        command <= it.cmd; hash_value <= it.hash; key_value <= it.key;
                        key_null <= it.nul; selected <= it.sel; row_index <= it.idx;
                        nv_in = 1;
                        if ($urandom_range(0, 60) == 0) burst = !burst;
                        gap_cnt = burst ? 0 : $urandom_range(0, 15);
                    end else if (settle >= 4) begin
                        item_t it;
                        it = item_q.pop_front();
                        if (it.kind == K_CFG) begin
                            cfg_index <= it.reg_idx;
                            cfg_data <= it.reg_data;
                            nv_cfg = 1;
                        end
                        settle = 0;
                    end
                end
            end
            in_valid <= nv_in;
            cfg_valid <= nv_cfg;
        end
    end

    // receiver stalls, with one long hold-off
    int  stall_cnt = 0;
    bit  long_done = 0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (out_taken) begin
                out_taken = 0;
                stall_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (!long_done && results_seen == 300) begin
                    stall_cnt = 600;
                    long_done = 1;
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            out_taken = 1;
            results_seen++;
            if (result_q.size() == 0) begin
                $error("unexpected result item: row_id %0d status %0d", row_id, status);
                errors++;
            end else begin
                result_t w;
                w = result_q.pop_front();
                if (row_id !== w.row) begin
                    $error("row_id expected %0d actual %0d", w.row, row_id);
                    errors++;
                end
                if (status !== w.st) begin
                    $error("status expected %0d actual %0d", w.st, status);
                    errors++;
                end
                if (stored_rows !== w.rows) begin
                    $error("stored_rows expected %0d actual %0d", w.rows, stored_rows);
                    errors++;
                end
            end
        end
    end

    // random item drawn from small pools so that hits, duplicates and chains occur
    logic [63:0] hash_pool [24];
    logic [63:0] key_pool  [6];
    int unsigned approx_rows;

    task automatic add_random();
        int unsigned pick;
        logic [63:0] h, k;
        logic [RW-1:0] i;
        cmd_t c;
        pick = $urandom_range(0, 99);
        if (pick < 30) c = CMD_FIND;
        else if (pick < 74) c = CMD_INSERT;
        else if (pick < 99) c = CMD_NEXT;
        else c = CMD_CLEAR;
        h = ($urandom_range(0, 19) == 0) ? rand64() : hash_pool[$urandom_range(0, 23)];
        k = ($urandom_range(0, 19) == 0) ? rand64() : key_pool[$urandom_range(0, 5)];
        if ($urandom_range(0, 9) == 0) i = RW'($urandom);
        else i = RW'($urandom_range(0, approx_rows + 2));
        if (c == CMD_INSERT) approx_rows++;
        if (c == CMD_CLEAR) approx_rows = 0;
        add_item(c, h, k, $urandom_range(0, 6) == 0, $urandom_range(0, 19) != 0, i);
    endtask

    initial begin
        logic [63:0] ha, ka;
        rst_n = 1'b0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0; command = '0; hash_value = '0; key_value = '0;
        key_null = 0; selected = 0; row_index = '0;
        out_ready = 0;
        m_multi = 0; m_limit = KEY_LIMIT_RST; m_hash_only = 0;
        empty_model();

        for (int i = 0; i < 24; i++) hash_pool[i] = rand64();
        for (int i = 1; i < 6; i++) hash_pool[i][12:0] = hash_pool[0][12:0];
        for (int i = 0; i < 6; i++) key_pool[i] = rand64();
        ha = hash_pool[0];
        ka = key_pool[0];

        // directed: set mode
        add_item(CMD_FIND, ha, ka, 0, 1, 0);
        add_item(CMD_INSERT, ha, ka, 0, 1, 0);
        add_item(CMD_INSERT, ha, ka, 0, 1, 0);
        add_item(CMD_INSERT, ha, ka, 1, 1, 0);
        add_item(CMD_FIND, ha, 64'h0, 1, 1, 0);
        add_item(CMD_INSERT, '1, '1, 0, 1, '1);
        add_item(CMD_FIND, '1, '1, 0, 1, 0);
        add_item(CMD_FIND, '0, '0, 0, 1, 0);
        add_item(CMD_NEXT, 0, 0, 0, 1, 0);
        add_item(CMD_NEXT, 0, 0, 0, 1, '1);
        add_item(CMD_INSERT, ha, ~ka, 0, 0, 0);
        add_item(CMD_CLEAR, 0, 0, 0, 1, 0);
        // directed: multiset groups, hash-only matching
        add_cfg(CFG_MULTISET, 1);
        add_item(CMD_INSERT, ha, ka, 0, 1, 0);
        add_item(CMD_INSERT, ha, ka, 0, 1, 0);
        add_item(CMD_INSERT, ha, ka, 0, 1, 0);
        add_item(CMD_NEXT, 0, 0, 0, 1, 0);
        add_item(CMD_NEXT, 0, 0, 0, 1, 1);
        add_item(CMD_FIND, ha, ka, 0, 1, 0);
        add_cfg(CFG_HASH_ONLY, 1);
        add_item(CMD_INSERT, ha, ~ka, 1, 1, 0);
        add_item(CMD_CLEAR, 0, 0, 0, 1, 0);
        // directed: limit of zero gives over limit on the second new key
        add_cfg(CFG_HASH_ONLY, 0);
        add_cfg(CFG_MULTISET, 0);
        add_cfg(CFG_KEY_LIMIT, 0);
        add_item(CMD_INSERT, ha, ka, 0, 1, 0);
        add_item(CMD_INSERT, ha, ~ka, 0, 1, 0);
        add_item(CMD_CLEAR, 0, 0, 0, 1, 0);

        // random phases under varying settings
        approx_rows = 0;
        for (int p = 0; p < 8; p++) begin
            add_cfg(CFG_MULTISET, $urandom_range(0, 1));
            add_cfg(CFG_HASH_ONLY, ($urandom_range(0, 3) == 0));
            case ($urandom_range(0, 3))
                0: add_cfg(CFG_KEY_LIMIT, 0);
                1: add_cfg(CFG_KEY_LIMIT, 4096);
                default: add_cfg(CFG_KEY_LIMIT, $urandom_range(0, 40));
            endcase
            for (int n = 0; n < 120; n++) begin
                add_random();
                if (p == 3 && n == 60) add_drain();
            end
        end

        repeat (5) @(posedge clk);
        rst_n = 1'b1;

        // wait until everything is sent and answered
        while (item_q.size() != 0 || in_valid || cfg_valid || result_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && result_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/chs_pkg.sv
hw/rtl/chs_ram.sv
hw/rtl/chs_match.sv
hw/rtl/chained_hash_set_insert_find.sv
hw/rtl/chs_checker.sv
verif/tb_chained_hash_set_insert_find.sv
